// ===== design/mpeg_audio_frame_crc_check_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the MPEG audio frame CRC checker
// Clocked, reset-qualified property wrappers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef MPEG_AUDIO_FRAME_CRC_CHECK_MACROS_SVH
`define MPEG_AUDIO_FRAME_CRC_CHECK_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define MAFCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked at every clock edge outside reset.
`define MAFCC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ===== design/mafcc_pkg.sv =====
// ----------------------------------------------------------------------------
// MPEG audio frame CRC checker package
// Verdict codes, CRC constants and side-info lengths.
// ----------------------------------------------------------------------------
package mafcc_pkg;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_MISMATCH    = 2'd1,
        ST_UNPROTECTED = 2'd2,
        ST_NOT_LAYER3  = 2'd3
    } t_status;

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_SEED = 16'hFFFF;

    localparam logic [5:0] SI_MPEG1_STEREO = 6'd32;
    localparam logic [5:0] SI_MPEG1_MONO   = 6'd17;
    localparam logic [5:0] SI_MPEG2_STEREO = 6'd17;
    localparam logic [5:0] SI_MPEG2_MONO   = 6'd9;

    // Byte positions inside a frame.
    localparam logic [5:0] POS_CRC_FIRST = 6'd2;
    localparam logic [5:0] POS_HDR_LAST  = 6'd3;
    localparam logic [5:0] POS_SI_FIRST  = 6'd6;
    // Highest position held while a frame is still open.
    localparam logic [5:0] POS_OPEN_MAX  = 6'd37;

    localparam logic [1:0] LAYER3_CODE = 2'd1;
    localparam logic [1:0] MODE_MONO   = 2'd3;

    function automatic logic [5:0] side_info_len(input logic [31:0] hdr);
        logic mono;
        mono = (hdr[7:6] == MODE_MONO);
        if (hdr[19]) begin
            return mono ? SI_MPEG1_MONO : SI_MPEG1_STEREO;
        end
        return mono ? SI_MPEG2_MONO : SI_MPEG2_STEREO;
    endfunction

endpackage

// ===== design/mafcc_crc_step.sv =====
// ----------------------------------------------------------------------------
// CRC-16 byte step
// Advances a CRC-16 (polynomial 0x8005, MSB first) by one data byte.
// ----------------------------------------------------------------------------
module mafcc_crc_step (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);
    import mafcc_pkg::*;

    always_comb begin
        logic [15:0] x;
        x = i_crc ^ {i_byte, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (x[15]) begin
                x = {x[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                x = {x[14:0], 1'b0};
            end
        end
        o_crc = x;
    end

endmodule

// ===== design/mpeg_audio_frame_crc_check.sv =====
// ----------------------------------------------------------------------------
// MPEG audio layer 3 frame CRC checker
// A verdict goes from the byte in the input register into the output register, which drives o_valid.
// Throughput: one byte per cycle while the result side keeps up, set by the single-byte CRC step.
// Reset (i_rst_n low, synchronous) empties both stages and closes any frame.
// ----------------------------------------------------------------------------
`include "mpeg_audio_frame_crc_check_macros.svh"

module mpeg_audio_frame_crc_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_crc_calc,
    output logic [15:0] o_crc_stored
);
    import mafcc_pkg::*;

    // The design has two stages. The input register captures one byte
    // request. The second stage updates the frame state (position, header,
    // running CRC, stored CRC) and, when the byte closes the checked part of
    // a frame, loads the verdict into the output register. The input stage
    // advances whenever the output register is empty or being drained, so a
    // byte is taken every cycle while the consumer keeps up.

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_start;

    // Frame state.
    logic        r_active, n_active;
    logic [5:0]  r_pos, n_pos;
    logic [31:0] r_hdr, n_hdr;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_fcv, n_fcv;

    // Output register.
    logic        r_out_valid;
    t_status     r_status, n_status;
    logic [15:0] r_crc_calc, n_crc_calc;
    logic [15:0] r_crc_stored, n_crc_stored;

    logic        advance;
    logic        emit;
    logic [15:0] crc_base;
    logic [15:0] crc_next;

    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte  <= i_data_byte;
            r_start <= i_frame_start;
        end
    end

    // A frame start discards whatever frame was open, so the CRC begins from
    // its initial value on the first byte of every frame.
    assign crc_base = r_start ? CRC_SEED : r_crc;

    mafcc_crc_step u_crc_step (
        .i_crc  (crc_base),
        .i_byte (r_byte),
        .o_crc  (crc_next)
    );

    always_comb begin
        logic        act;
        logic [5:0]  pos;
        logic [31:0] hdr_base;
        logic [15:0] fcv_base;
        logic [31:0] hdr_new;
        logic [6:0]  si_end;

        act      = r_start || r_active;
        pos      = r_start ? 6'd0 : r_pos;
        hdr_base = r_start ? 32'd0 : r_hdr;
        fcv_base = r_start ? 16'd0 : r_fcv;
        hdr_new  = {hdr_base[23:0], r_byte};
        si_end   = {1'b0, POS_SI_FIRST} + {1'b0, side_info_len(hdr_base)};

        n_active     = act;
        n_pos        = pos;
        n_hdr        = hdr_base;
        n_crc        = crc_base;
        n_fcv        = fcv_base;
        emit         = 1'b0;
        n_status     = ST_OK;
        n_crc_calc   = 16'd0;
        n_crc_stored = 16'd0;

        if (act) begin
            n_pos = pos + 6'd1;
            if (pos <= POS_HDR_LAST) begin
                // Header bytes; only bytes 2 and 3 enter the CRC.
                n_hdr = hdr_new;
                if (pos >= POS_CRC_FIRST) begin
                    n_crc = crc_next;
                end
                if (pos == POS_HDR_LAST) begin
                    if (hdr_new[16]) begin
                        emit     = 1'b1;
                        n_status = ST_UNPROTECTED;
                    end else if (hdr_new[18:17] != LAYER3_CODE) begin
                        emit     = 1'b1;
                        n_status = ST_NOT_LAYER3;
                    end
                end
            end else if (pos < POS_SI_FIRST) begin
                // Stored CRC, big-endian.
                n_fcv = {fcv_base[7:0], r_byte};
            end else begin
                // Side information.
                n_crc = crc_next;
                if (({1'b0, pos} + 7'd1) >= si_end) begin
                    emit         = 1'b1;
                    n_status     = (crc_next == fcv_base) ? ST_OK : ST_MISMATCH;
                    n_crc_calc   = crc_next;
                    n_crc_stored = fcv_base;
                end
            end
            if (emit) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= 6'd0;
            r_hdr    <= 32'd0;
            r_crc    <= CRC_SEED;
            r_fcv    <= 16'd0;
        end else if (r_in_valid && advance) begin
            r_active <= n_active;
            r_pos    <= n_pos;
            r_hdr    <= n_hdr;
            r_crc    <= n_crc;
            r_fcv    <= n_fcv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance && emit) begin
            r_status     <= n_status;
            r_crc_calc   <= n_crc_calc;
            r_crc_stored <= n_crc_stored;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_crc_calc   = r_crc_calc;
    assign o_crc_stored = r_crc_stored;

    // A pass verdict always carries equal CRC values, a fail verdict unequal
    // ones, and the unchecked verdicts carry zeros.
    logic        crc_equal;
    logic        crc_zero;
    logic        out_ok;
    logic        out_bad;
    logic        out_unchecked;

    assign crc_equal     = (r_crc_calc == r_crc_stored);
    assign crc_zero      = (r_crc_calc == 16'd0) && (r_crc_stored == 16'd0);
    assign out_ok        = o_valid && (r_status == ST_OK);
    assign out_bad       = o_valid && (r_status == ST_MISMATCH);
    assign out_unchecked = o_valid &&
                           ((r_status == ST_UNPROTECTED) || (r_status == ST_NOT_LAYER3));

    `MAFCC_ASSERT_IMP(a_ok_equal, i_clk, i_rst_n, out_ok, crc_equal, "pass verdict, CRCs differ")
    `MAFCC_ASSERT_IMP(a_bad_differs, i_clk, i_rst_n, out_bad, !crc_equal, "fail, CRCs equal")
    `MAFCC_ASSERT_IMP(a_unchecked_zero, i_clk, i_rst_n, out_unchecked, crc_zero, "CRC not zero")
    `MAFCC_ASSERT_IMP(a_pos_bound, i_clk, i_rst_n, r_active, r_pos <= POS_OPEN_MAX, "overrun")

endmodule

// ===== verif/mpeg_audio_frame_crc_check_tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the MPEG audio layer 3 frame CRC checker
// Sends frame byte streams through the valid/ready request port and checks
// every verdict against an in-bench model of the header capture and CRC-16.
// Both ports idle and stall at random, with stretches of full throughput.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_crc_check_tb;

    import mafcc_pkg::*;

    // Live (non-ignored) bytes to send before the random phase stops.
    localparam int RAND_ITEMS   = 1150;
    // Cycles waited after every expected verdict has been delivered.
    localparam int DRAIN_CYCLES = 8;
    // Hard limit on the whole run, far above the slowest legal run.
    localparam int CYCLE_LIMIT  = 400000;

    // Shapes of generated frames.
    typedef enum int {
        FK_GOOD,
        FK_BAD_CRC,
        FK_UNPROT,
        FK_OTHER_LAYER
    } t_frame_kind;

    typedef struct packed {
        t_status     status;
        logic [15:0] crc_calc;
        logic [15:0] crc_stored;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_frame_start = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_crc_calc;
    logic [15:0] o_crc_stored;

    mpeg_audio_frame_crc_check uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_frame_start(i_frame_start),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_crc_calc   (o_crc_calc),
        .o_crc_stored (o_crc_stored)
    );

    always #4 i_clk = ~i_clk;

    // Verdicts the model has produced that the block has not delivered yet.
    t_verdict exp_verdicts[$];

    // Model state: one open frame at most, tracked byte by byte.
    logic [5:0]  fr_pos = '0;
    logic [31:0] fr_hdr = '0;
    logic [15:0] fr_crc = CRC_SEED;
    logic [15:0] fr_stored = '0;
    logic        fr_open = 1'b0;

    int  live_items = 0;
    int  err_count = 0;
    int  cycle_count = 0;
    int  rx_hold = 0;
    // When set, the matching side runs without any idle cycles.
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    // One byte of CRC-16, polynomial 0x8005, MSB first, no reflection.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Side-info length follows the version bit and whether the mode is mono.
    // Version 2.5 clears bit 19 and falls to MPEG-2; the reserved code sets it and falls to MPEG-1.
    function automatic int si_bytes(input logic [31:0] hdr);
        if (hdr[19]) begin
            return (hdr[7:6] == MODE_MONO) ? int'(SI_MPEG1_MONO) : int'(SI_MPEG1_STEREO);
        end
        return (hdr[7:6] == MODE_MONO) ? int'(SI_MPEG2_MONO) : int'(SI_MPEG2_STEREO);
    endfunction

    function automatic void note_failure(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // Close the frame and queue the verdict the block must deliver.
    function automatic void post_verdict(input t_status st, input logic [15:0] calc,
                                         input logic [15:0] stored);
        t_verdict v;
        v.status = st;
        v.crc_calc = calc;
        v.crc_stored = stored;
        exp_verdicts.push_back(v);
        fr_open = 1'b0;
    endfunction

    // Advance the model by one accepted request.
    function automatic void track_frame_byte(input logic [7:0] b, input logic s);
        int p;
        if (s) begin
            // A start flag always opens a fresh frame, even over an open one.
            fr_open = 1'b1;
            fr_pos = '0;
            fr_hdr = '0;
            fr_crc = CRC_SEED;
            fr_stored = '0;
        end
        if (!fr_open) begin
            return;
        end
        live_items++;
        p = fr_pos;
        fr_pos = fr_pos + 6'd1;
        if (p < 4) begin
            fr_hdr = {fr_hdr[23:0], b};
            if (p >= 2) begin
                fr_crc = crc16_byte(fr_crc, b);
            end
            if (p == 3) begin
                // The protection bit set means no CRC; that wins over the layer test.
                if (fr_hdr[16]) begin
                    post_verdict(ST_UNPROTECTED, 16'h0000, 16'h0000);
                end else if (fr_hdr[18:17] != LAYER3_CODE) begin
                    post_verdict(ST_NOT_LAYER3, 16'h0000, 16'h0000);
                end
            end
        end else if (p < 6) begin
            fr_stored = {fr_stored[7:0], b};
        end else begin
            fr_crc = crc16_byte(fr_crc, b);
            if (p + 1 >= 6 + si_bytes(fr_hdr)) begin
                post_verdict((fr_crc == fr_stored) ? ST_OK : ST_MISMATCH, fr_crc, fr_stored);
            end
        end
    endfunction

    // Offer one request after a random gap and hold it until accepted. Valid is
    // left high on return so that a back-to-back request never lowers it.
    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_frame_start <= s;
        do @(posedge i_clk); while (!o_ready);
        track_frame_byte(b, s);
    endtask

    // Bytes without a start flag; ignored unless a frame is still open.
    task automatic send_stray(input int n);
        for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom), 1'b0);
        end
    endtask

    // Build a frame around the given header and send its first keep bytes
    // (all of them when keep is negative), then tail ignored bytes.
    task automatic send_frame(input t_frame_kind kind, input logic [31:0] hdr_in,
                              input int keep, input int tail);
        logic [7:0]  fb[$];
        logic [7:0]  si;
        logic [31:0] hdr;
        logic [15:0] crc;
        int          n_si;
        int          len;
        hdr = hdr_in;
        case (kind)
            FK_UNPROT: begin
                hdr[16] = 1'b1;
            end
            FK_OTHER_LAYER: begin
                hdr[16] = 1'b0;
                while (hdr[18:17] == LAYER3_CODE) begin
                    hdr[18:17] = 2'($urandom_range(0, 3));
                end
            end
            default: begin
                hdr[16] = 1'b0;
                hdr[18:17] = LAYER3_CODE;
            end
        endcase
        fb = {hdr[31:24], hdr[23:16], hdr[15:8], hdr[7:0]};
        if (kind == FK_GOOD || kind == FK_BAD_CRC) begin
            n_si = si_bytes(hdr);
            crc = crc16_byte(crc16_byte(CRC_SEED, hdr[15:8]), hdr[7:0]);
            fb.push_back(8'h00);
            fb.push_back(8'h00);
            for (int i = 0; i < n_si; i++) begin
                case ($urandom_range(0, 9))
                    0:       si = 8'h00;
                    1:       si = 8'hFF;
                    default: si = 8'($urandom);
                endcase
                crc = crc16_byte(crc, si);
                fb.push_back(si);
            end
            if (kind == FK_BAD_CRC) begin
                crc = crc ^ 16'($urandom_range(1, 65535));
            end
            fb[4] = crc[15:8];
            fb[5] = crc[7:0];
        end
        len = fb.size();
        if (keep >= 0 && keep < len) begin
            len = keep;
        end
        for (int i = 0; i < len; i++) begin
            send_byte(fb[i], i == 0);
        end
        send_stray(tail);
    endtask

    // Stop sending and wait until every queued verdict has been delivered.
    task automatic wait_for_verdicts();
        i_valid <= 1'b0;
        while (exp_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Header-only verdicts: a stray byte before any frame, an unprotected frame
    // of all ones, and a protected frame of all zeros with the reserved layer.
    task automatic test_header_verdicts();
        send_stray(1);
        send_frame(FK_UNPROT, 32'hFFFF_FFFF, -1, 0);
        send_frame(FK_OTHER_LAYER, 32'h0000_0000, -1, 0);
    endtask

    // A frame cut short by a new start flag, then a complete protected layer 3
    // frame of version 2.5 in mono (nine side-info bytes), then a byte after
    // the verdict that must be ignored.
    task automatic test_restart_and_v25();
        send_frame(FK_GOOD, 32'hFFE2_50C4, 2, 0);
        send_frame(FK_GOOD, 32'hFFE2_50C4, -1, 1);
    endtask

    // Mostly well-formed protected layer 3 frames with random headers and side
    // info, mixed with bad CRCs, header-only frames, cut frames and noise.
    task automatic test_random_frames();
        int  r;
        int  tail;
        bit  paused;
        paused = 1'b0;
        while (live_items < RAND_ITEMS) begin
            tx_steady = ($urandom_range(0, 9) == 0);
            rx_steady = ($urandom_range(0, 9) == 0);
            // Once, halfway through, let the pipeline run dry before going on.
            if (!paused && live_items >= RAND_ITEMS / 2) begin
                wait_for_verdicts();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            if (r < 55) begin
                send_frame(FK_GOOD, $urandom, -1, tail);
            end else if (r < 70) begin
                send_frame(FK_BAD_CRC, $urandom, -1, tail);
            end else if (r < 80) begin
                send_frame(FK_UNPROT, $urandom, -1, tail);
            end else if (r < 88) begin
                send_frame(FK_OTHER_LAYER, $urandom, -1, tail);
            end else if (r < 95) begin
                // May be cut before the verdict; the next start flag abandons a cut frame.
                send_frame(FK_GOOD, $urandom, $urandom_range(1, 37), 0);
            end else begin
                send_stray($urandom_range(1, 3));
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Result side: after each delivered verdict, hold ready low for a random
    // number of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold = 0;
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                rx_hold = rx_steady ? 0 : $urandom_range(0, 16);
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            i_ready <= (rx_hold == 0);
        end
    end

    // Compare each delivered verdict with the oldest expected one.
    always @(posedge i_clk) begin : check_verdict
        t_verdict want;
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_verdicts.size() == 0) begin
                note_failure($sformatf("unexpected verdict status=%0d calc=%04h stored=%04h",
                                       o_status, o_crc_calc, o_crc_stored));
            end else begin
                want = exp_verdicts.pop_front();
                if (o_status !== want.status || o_crc_calc !== want.crc_calc ||
                    o_crc_stored !== want.crc_stored) begin
                    note_failure($sformatf(
                        "verdict mismatch: expected %0d/%04h/%04h, got %0d/%04h/%04h",
                        want.status, want.crc_calc, want.crc_stored,
                        o_status, o_crc_calc, o_crc_stored));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("mpeg_audio_frame_crc_check_tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_header_verdicts();
        test_restart_and_v25();
        test_random_frames();
        wait_for_verdicts();
        if (err_count == 0 && exp_verdicts.size() == 0) begin
            $display("mpeg_audio_frame_crc_check_tb: clean");
        end else begin
            $display("mpeg_audio_frame_crc_check_tb: errors");
        end
        $finish;
    end

endmodule
